/* rtl/gsp_pkg.sv */
// ----------------------------------------------------------------------------
// gsp_pkg: shared types and constants
// Widths, register indexes, reset values and the command and status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package gsp_pkg;

    localparam int ANGLE_W    = 21;
    localparam int ERR_W      = 22;
    localparam int ESUM_W     = 23;
    localparam int TORQUE_W   = 23;
    localparam int GAIN_W     = 26;
    localparam int THRESH_W   = 20;
    localparam int LIMIT_W    = 22;
    localparam int VEL_W      = 32;
    localparam int VSUM_W     = 34;
    localparam int INTEG_W    = 48;
    localparam int FRAC_W     = 16;
    localparam int PROD_W     = 58;
    localparam int ACC_W      = 60;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 26;

    // constant divider: 6 quotient bits per cycle over a 36-bit dividend
    localparam int DIV_W      = 36;
    localparam int DIV_DIGITS = 6;
    localparam int DIV_STEPS  = DIV_W / DIV_DIGITS;
    localparam int DIV_CNT_W  = 3;
    localparam int REM_W      = 8;

    // 65536 / 2000 reduces to 4096 / 125
    localparam int INT_SHIFT  = 12;

    localparam logic [REM_W-1:0]  DIVISOR_3   = 8'd3;
    localparam logic [REM_W-1:0]  DIVISOR_125 = 8'd125;
    localparam logic [GAIN_W-1:0] VEL_SCALE   = 26'd1000;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_LARGE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_LARGE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_SMALL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_SMALL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TORQUE_LIMIT = 3'd6;

    localparam logic [GAIN_W-1:0]   RST_PROP_LARGE   = 26'd2949120;
    localparam logic [GAIN_W-1:0]   RST_DERIV_LARGE  = 26'd98304;
    localparam logic [GAIN_W-1:0]   RST_PROP_SMALL   = 26'd1966080;
    localparam logic [GAIN_W-1:0]   RST_DERIV_SMALL  = 26'd163840;
    localparam logic [GAIN_W-1:0]   RST_INTEGRAL     = 26'd29491200;
    localparam logic [THRESH_W-1:0] RST_THRESHOLD    = 20'd1311;
    localparam logic [LIMIT_W-1:0]  RST_TORQUE_LIMIT = 22'd327680;

    typedef enum logic {
        DIV_BY_3,
        DIV_BY_125
    } div_sel_t;

    typedef enum logic [2:0] {
        MS_VEL,
        MS_KP,
        MS_KD,
        MS_KIH,
        MS_KIL
    } mul_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_SUB,
        ACC_ADD,
        ACC_ADD_FRAC
    } acc_op_t;

    typedef struct packed {
        logic     load_in;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     div_start;
        div_sel_t div_sel;
        logic     latch_vel;
        logic     latch_cand;
        logic     commit;
    } gsp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic err_small;
    } gsp_stat_t;

endpackage

/* rtl/gsp_cdiv.sv */
// ----------------------------------------------------------------------------
// gsp_cdiv: iterative divider by a small constant
// Restoring division of an unsigned dividend by 3 or 125, six quotient
// bits per cycle; done pulses in the cycle after the last step.
// ----------------------------------------------------------------------------
module gsp_cdiv
    import gsp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  div_sel_t         sel,
    input  logic [DIV_W-1:0] dividend,
    output logic [DIV_W-1:0] quotient,
    output logic             done
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    div_sel_t              sel_reg;
    logic [DIV_W-1:0]      dvd_reg;
    logic [DIV_W-1:0]      quot_reg;
    logic [REM_W-2:0]      rem_reg;
    logic [REM_W-2:0]      rem_next;
    logic [REM_W-1:0]      divisor;
    logic [REM_W-1:0]      r;
    logic [DIV_DIGITS-1:0] qbits;

    always_comb
    begin
        divisor = (sel_reg == DIV_BY_125) ? DIVISOR_125 : DIVISOR_3;
        r       = {1'b0, rem_reg};
        qbits   = '0;
        for (int i = 0; i < DIV_DIGITS; i++)
        begin
            r = {r[REM_W-2:0], dvd_reg[DIV_W-1-i]};
            if (r >= divisor)
            begin
                r = r - divisor;
                qbits[DIV_DIGITS-1-i] = 1'b1;
            end
        end
        rem_next = r[REM_W-2:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sel_reg  <= sel;
            dvd_reg  <= dividend;
            quot_reg <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg  <= dvd_reg << DIV_DIGITS;
            quot_reg <= {quot_reg[DIV_W-DIV_DIGITS-1:0], qbits};
            rem_reg  <= rem_next;
        end
    end

    assign quotient = quot_reg;
    assign done     = done_reg;

endmodule

/* rtl/gsp_dp.sv */
// ----------------------------------------------------------------------------
// gsp_dp: controller datapath
// Configuration registers, loop state, shared multiplier, accumulator,
// constant divider and the output clamp.
// ----------------------------------------------------------------------------
module gsp_dp
    import gsp_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  gsp_cmd_t                     cmd,
    output gsp_stat_t                    stat,
    input  logic signed [ANGLE_W-1:0]    desired_angle,
    input  logic signed [ANGLE_W-1:0]    measured_angle,
    input  logic                         cfg_we,
    input  logic        [CFG_IDX_W-1:0]  cfg_index,
    input  logic        [CFG_DATA_W-1:0] cfg_data,
    output logic signed [TORQUE_W-1:0]   torque
);

    // configuration
    logic [GAIN_W-1:0]   kpl_reg;
    logic [GAIN_W-1:0]   kdl_reg;
    logic [GAIN_W-1:0]   kps_reg;
    logic [GAIN_W-1:0]   kds_reg;
    logic [GAIN_W-1:0]   ki_reg;
    logic [THRESH_W-1:0] thresh_reg;
    logic [LIMIT_W-1:0]  limit_reg;

    // loop state
    logic signed [ANGLE_W-1:0] prev_angle_reg;
    logic signed [VEL_W-1:0]   hist0_reg;
    logic signed [VEL_W-1:0]   hist1_reg;
    logic signed [ERR_W-1:0]   prev_error_reg;
    logic signed [INTEG_W-1:0] integ_reg;
    logic signed [INTEG_W-1:0] integ_next;

    // per-item working registers
    logic signed [ERR_W-1:0]    error_reg;
    logic signed [ERR_W-1:0]    dpos_reg;
    logic signed [ANGLE_W-1:0]  meas_reg;
    logic                       inside_reg;
    logic                       neg_reg;
    logic signed [VEL_W-1:0]    vel_reg;
    logic signed [INTEG_W-1:0]  cand_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [TORQUE_W-1:0] torque_reg;

    logic signed [ERR_W-1:0]    err_in;
    logic        [ERR_W-1:0]    err_abs;
    logic                       inside_in;

    logic        [GAIN_W-1:0]   mul_a;
    logic signed [VEL_W-1:0]    mul_b;
    logic signed [PROD_W:0]     prod_full;

    logic signed [VSUM_W-1:0]   vsum;
    logic        [VSUM_W-1:0]   vsum_abs;
    logic signed [ESUM_W-1:0]   esum;
    logic        [ESUM_W-1:0]   esum_abs;
    logic        [DIV_W-1:0]    div_dividend;
    logic        [DIV_W-1:0]    div_quot;
    logic                       div_done;
    logic                       div_neg;

    logic signed [INTEG_W:0]    q_ext;
    logic signed [INTEG_W:0]    cand_sum;
    logic signed [INTEG_W-1:0]  cand_sat;
    logic signed [VEL_W-1:0]    vel_q;

    logic signed [ACC_W-1:0]    prod_ext;
    logic signed [ACC_W-1:0]    lim_ext;
    logic                       sat_hi;
    logic                       sat_lo;
    logic signed [TORQUE_W-1:0] torque_next;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kpl_reg    <= RST_PROP_LARGE;
            kdl_reg    <= RST_DERIV_LARGE;
            kps_reg    <= RST_PROP_SMALL;
            kds_reg    <= RST_DERIV_SMALL;
            ki_reg     <= RST_INTEGRAL;
            thresh_reg <= RST_THRESHOLD;
            limit_reg  <= RST_TORQUE_LIMIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PROP_LARGE:   kpl_reg    <= cfg_data;
                REG_DERIV_LARGE:  kdl_reg    <= cfg_data;
                REG_PROP_SMALL:   kps_reg    <= cfg_data;
                REG_DERIV_SMALL:  kds_reg    <= cfg_data;
                REG_INTEGRAL:     ki_reg     <= cfg_data;
                REG_THRESHOLD:    thresh_reg <= cfg_data[THRESH_W-1:0];
                REG_TORQUE_LIMIT: limit_reg  <= cfg_data[LIMIT_W-1:0];
                default:          ;
            endcase
        end
    end

    // input stage
    assign err_in    = {desired_angle[ANGLE_W-1], desired_angle}
                     - {measured_angle[ANGLE_W-1], measured_angle};
    assign err_abs   = err_in[ERR_W-1] ? ERR_W'(-err_in) : ERR_W'(err_in);
    assign inside_in = err_abs < {{(ERR_W-THRESH_W){1'b0}}, thresh_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            error_reg  <= err_in;
            dpos_reg   <= {measured_angle[ANGLE_W-1], measured_angle}
                        - {prev_angle_reg[ANGLE_W-1], prev_angle_reg};
            meas_reg   <= measured_angle;
            inside_reg <= inside_in;
        end
    end

    // shared multiplier
    always_comb
    begin
        case (cmd.mul_sel)
            MS_VEL:
            begin
                mul_a = VEL_SCALE;
                mul_b = VEL_W'(dpos_reg);
            end
            MS_KP:
            begin
                mul_a = inside_reg ? kps_reg : kpl_reg;
                mul_b = VEL_W'(error_reg);
            end
            MS_KD:
            begin
                mul_a = inside_reg ? kds_reg : kdl_reg;
                mul_b = vel_reg;
            end
            MS_KIH:
            begin
                mul_a = ki_reg;
                mul_b = cand_reg[INTEG_W-1:FRAC_W];
            end
            MS_KIL:
            begin
                mul_a = ki_reg;
                mul_b = {{(VEL_W-FRAC_W){1'b0}}, cand_reg[FRAC_W-1:0]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_full = $signed({1'b0, mul_a}) * mul_b;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_full[PROD_W-1:0];
    end

    // divider operands: velocity sum and error sum
    assign vsum     = VSUM_W'($signed(prod_reg[VEL_W-1:0])) + VSUM_W'(hist0_reg)
                    + VSUM_W'(hist1_reg);
    assign vsum_abs = vsum[VSUM_W-1] ? VSUM_W'(-vsum) : VSUM_W'(vsum);
    assign esum     = ESUM_W'(error_reg) + ESUM_W'(prev_error_reg);
    assign esum_abs = esum[ESUM_W-1] ? ESUM_W'(-esum) : ESUM_W'(esum);

    assign div_dividend = (cmd.div_sel == DIV_BY_3)
                        ? {{(DIV_W-VSUM_W){1'b0}}, vsum_abs}
                        : {{(DIV_W-ESUM_W-INT_SHIFT){1'b0}}, esum_abs,
                           {INT_SHIFT{1'b0}}};
    assign div_neg      = (cmd.div_sel == DIV_BY_3) ? vsum[VSUM_W-1] : esum[ESUM_W-1];

    gsp_cdiv u_cdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .sel      (cmd.div_sel),
        .dividend (div_dividend),
        .quotient (div_quot),
        .done     (div_done)
    );

    // signed quotients and saturated integral candidate
    assign vel_q    = neg_reg ? -$signed(div_quot[VEL_W-1:0]) : $signed(div_quot[VEL_W-1:0]);
    assign q_ext    = $signed({{(INTEG_W+1-DIV_W){1'b0}}, div_quot});
    assign cand_sum = {integ_reg[INTEG_W-1], integ_reg} + (neg_reg ? -q_ext : q_ext);

    always_comb
    begin
        if (cand_sum[INTEG_W] != cand_sum[INTEG_W-1])
        begin
            cand_sat = cand_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                         : {1'b0, {(INTEG_W-1){1'b1}}};
        end
        else
        begin
            cand_sat = cand_sum[INTEG_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            neg_reg <= div_neg;
        end
        if (cmd.latch_vel)
        begin
            vel_reg <= vel_q;
        end
        if (cmd.latch_cand)
        begin
            cand_reg <= cand_sat;
        end
    end

    // accumulator
    assign prod_ext = ACC_W'(prod_reg);

    always_ff @(posedge clk)
    begin
        case (cmd.acc_op)
            ACC_LOAD:     acc_reg <= prod_ext;
            ACC_SUB:      acc_reg <= acc_reg - prod_ext;
            ACC_ADD:      acc_reg <= acc_reg + prod_ext;
            ACC_ADD_FRAC: acc_reg <= acc_reg + ACC_W'(prod_reg[PROD_W-1:FRAC_W]);
            default:      ;
        endcase
    end

    // clamp and integral update
    assign lim_ext = $signed({{(ACC_W-LIMIT_W-FRAC_W){1'b0}}, limit_reg, {FRAC_W{1'b0}}});
    assign sat_hi  = acc_reg > lim_ext;
    assign sat_lo  = acc_reg < -lim_ext;

    always_comb
    begin
        if (sat_hi)
        begin
            torque_next = $signed({1'b0, limit_reg});
        end
        else if (sat_lo)
        begin
            torque_next = -$signed({1'b0, limit_reg});
        end
        else
        begin
            torque_next = acc_reg[TORQUE_W+FRAC_W-1:FRAC_W];
        end

        if (!inside_reg)
        begin
            integ_next = '0;
        end
        else if (sat_hi || sat_lo)
        begin
            integ_next = integ_reg;
        end
        else
        begin
            integ_next = cand_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_angle_reg <= '0;
            hist0_reg      <= '0;
            hist1_reg      <= '0;
            prev_error_reg <= '0;
            integ_reg      <= '0;
        end
        else if (cmd.commit)
        begin
            prev_angle_reg <= meas_reg;
            hist1_reg      <= hist0_reg;
            hist0_reg      <= vel_reg;
            prev_error_reg <= error_reg;
            integ_reg      <= integ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            torque_reg <= torque_next;
        end
    end

    assign stat.div_done  = div_done;
    assign stat.err_small = inside_reg;
    assign torque         = torque_reg;

endmodule

/* rtl/gsp_ctrl.sv */
// ----------------------------------------------------------------------------
// gsp_ctrl: sequencer
// Steps the datapath through velocity filter, integral update, gain
// products and clamp; owns the input ready and the output valid.
// ----------------------------------------------------------------------------
module gsp_ctrl
    import gsp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output gsp_cmd_t  cmd,
    input  gsp_stat_t stat
);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_RAWV  = 11'b000_0000_0010,
        ST_VSUM  = 11'b000_0000_0100,
        ST_VDIV  = 11'b000_0000_1000,
        ST_IDIV  = 11'b000_0001_0000,
        ST_MP    = 11'b000_0010_0000,
        ST_MD    = 11'b000_0100_0000,
        ST_MI    = 11'b000_1000_0000,
        ST_ML    = 11'b001_0000_0000,
        ST_MA    = 11'b010_0000_0000,
        ST_CLAMP = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd            = '{load_in: 1'b0, mul_sel: MS_VEL, acc_op: ACC_HOLD,
                           div_start: 1'b0, div_sel: DIV_BY_3, latch_vel: 1'b0,
                           latch_cand: 1'b0, commit: 1'b0};
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_RAWV;
                end
            end
            ST_RAWV:
            begin
                cmd.mul_sel = MS_VEL;
                state_next  = ST_VSUM;
            end
            ST_VSUM:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_BY_3;
                state_next    = ST_VDIV;
            end
            ST_VDIV:
            begin
                if (stat.div_done)
                begin
                    cmd.latch_vel = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_BY_125;
                    state_next    = ST_IDIV;
                end
            end
            ST_IDIV:
            begin
                cmd.div_sel = DIV_BY_125;
                if (stat.div_done)
                begin
                    cmd.latch_cand = 1'b1;
                    state_next     = ST_MP;
                end
            end
            ST_MP:
            begin
                cmd.mul_sel = MS_KP;
                state_next  = ST_MD;
            end
            ST_MD:
            begin
                cmd.acc_op  = ACC_LOAD;
                cmd.mul_sel = MS_KD;
                state_next  = ST_MI;
            end
            ST_MI:
            begin
                cmd.acc_op  = ACC_SUB;
                cmd.mul_sel = MS_KIH;
                state_next  = stat.err_small ? ST_ML : ST_CLAMP;
            end
            ST_ML:
            begin
                cmd.acc_op  = ACC_ADD;
                cmd.mul_sel = MS_KIL;
                state_next  = ST_MA;
            end
            ST_MA:
            begin
                cmd.acc_op = ACC_ADD_FRAC;
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                if (slot_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* rtl/gain_switched_pid_antiwindup.sv */
// ----------------------------------------------------------------------------
// gain_switched_pid_antiwindup: gain-switched PID joint torque controller
// Filtered velocity, trapezoidal integral with conditional integration,
// gain switching on error magnitude and a symmetric torque clamp.
//
//   channel  handshake             payload
//   in       in_valid / in_ready   desired_angle, measured_angle
//   out      out_valid / out_ready torque
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// the result is valid after RAWV, VSUM, VDIV, IDIV, MP, MD, MI, then ML
// and MA inside the threshold only, and CLAMP; the next item can be accepted
// from the cycle in which it turns valid; the two passes of the constant divider
// and the one shared multiplier set the length of that sequence
// reset loads the default gains and clears the loop state
// the result waits in an output register, so the next item is accepted
// while it is stalled; only a finished item meeting a full register waits
// configuration writes are taken every cycle
// ----------------------------------------------------------------------------
module gain_switched_pid_antiwindup
    import gsp_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [ANGLE_W-1:0]    desired_angle,
    input  logic signed [ANGLE_W-1:0]    measured_angle,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [TORQUE_W-1:0]   torque,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic        [CFG_IDX_W-1:0]  cfg_index,
    input  logic        [CFG_DATA_W-1:0] cfg_data
);

    gsp_cmd_t  cmd;
    gsp_stat_t stat;

    assign cfg_ready = 1'b1;

    gsp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    gsp_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .desired_angle  (desired_angle),
        .measured_angle (measured_angle),
        .cfg_we         (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .torque         (torque)
    );

endmodule

/* rtl/gsp_chk.sv */
// ----------------------------------------------------------------------------
// gsp_chk: port-level checks
// Watches the top level ports for output hold, item accounting and the
// torque clamp, and is bound to the top level.
// ----------------------------------------------------------------------------
module gsp_chk
    import gsp_pkg::*;
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic signed [TORQUE_W-1:0]   torque,
    input logic                         cfg_valid,
    input logic                         cfg_ready,
    input logic        [CFG_IDX_W-1:0]  cfg_index,
    input logic        [CFG_DATA_W-1:0] cfg_data
);

    logic [1:0]         pend_reg;
    logic [LIMIT_W-1:0] lim_reg;
    logic               in_acc;
    logic               out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // items accepted but not yet delivered, and a copy of the torque limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            lim_reg  <= RST_TORQUE_LIMIT;
        end
        else
        begin
            pend_reg <= pend_reg + {1'b0, in_acc} - {1'b0, out_acc};
            if (cfg_valid && cfg_ready && cfg_index == REG_TORQUE_LIMIT)
            begin
                lim_reg <= cfg_data[LIMIT_W-1:0];
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(torque))
        else $error("torque item changed while stalled");

    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("input ready right after an accepted item");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result item with no accepted input");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("too many items in flight");

    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (torque <= $signed({1'b0, lim_reg}))
                   && (torque >= -$signed({1'b0, lim_reg})))
        else $error("torque outside the limit");

endmodule

bind gain_switched_pid_antiwindup gsp_chk u_gsp_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .torque    (torque),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);

/* bench/gain_switched_pid_antiwindup_test.sv */
// ----------------------------------------------------------------------------
// gain_switched_pid_antiwindup_test: self-checking bench for the joint
// torque controller
// Drives angle samples through a valid/ready driver with random gaps, takes
// torque items through a monitor with random back-pressure, and checks each
// one against a cycle-free model of the filter, integral, gain switch and
// clamp that is stepped as samples are accepted. Register settings change
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module gain_switched_pid_antiwindup_test;
    import gsp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ANGLE_MAX = (1 << (ANGLE_W - 1)) - 1;
    localparam int ANGLE_MIN = -(1 << (ANGLE_W - 1));
    localparam int LIMIT_MAX = (1 << LIMIT_W) - 1;
    localparam longint INTEG_MAX = (longint'(1) <<< (INTEG_W - 1)) - 1;
    localparam longint INTEG_MIN = -INTEG_MAX - 1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int PHASE_ITEMS = 55;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] desired;
        logic signed [ANGLE_W-1:0] measured;
    } sample_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic signed [ANGLE_W-1:0]    desired_angle = '0;
    logic signed [ANGLE_W-1:0]    measured_angle = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic signed [TORQUE_W-1:0]   torque;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic        [CFG_IDX_W-1:0]  cfg_index = '0;
    logic        [CFG_DATA_W-1:0] cfg_data = '0;

    // controller model: registers and loop state
    logic [GAIN_W-1:0]          kp_large = RST_PROP_LARGE;
    logic [GAIN_W-1:0]          kd_large = RST_DERIV_LARGE;
    logic [GAIN_W-1:0]          kp_small = RST_PROP_SMALL;
    logic [GAIN_W-1:0]          kd_small = RST_DERIV_SMALL;
    logic [GAIN_W-1:0]          ki_gain = RST_INTEGRAL;
    logic [THRESH_W-1:0]        err_thresh = RST_THRESHOLD;
    logic [LIMIT_W-1:0]         torque_lim = RST_TORQUE_LIMIT;
    logic signed [ANGLE_W-1:0]  last_angle = '0;
    logic signed [VEL_W-1:0]    vel_hist [2] = '{default: '0};
    logic signed [ERR_W-1:0]    last_error = '0;
    logic signed [INTEG_W-1:0]  integ_acc = '0;

    sample_t                    sample_queue [$];
    logic signed [TORQUE_W-1:0] torque_expected [$];
    logic signed [TORQUE_W-1:0] torque_want;
    sample_t                    next_sample;
    int                         samples_unsent = 0;
    bit                         in_taken = 1'b0;
    bit                         throttle = 1'b1;
    int                         hold_request = 0;
    int                         hold_left = 0;
    int                         cycle_count = 0;
    int                         mismatch_count = 0;
    int                         samples_taken = 0;
    int                         band_count = 0;
    int                         clamp_count = 0;
    int                         settings_used = 0;

    gain_switched_pid_antiwindup DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .desired_angle  (desired_angle),
        .measured_angle (measured_angle),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .torque         (torque),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic logic signed [TORQUE_W-1:0] predict_torque(
        input logic signed [ANGLE_W-1:0] desired,
        input logic signed [ANGLE_W-1:0] measured
    );
        longint err, vel, cand, mag, ih, il, t, lim;
        bit     in_band;
        err = longint'(desired) - longint'(measured);
        vel = ((longint'(measured) - longint'(last_angle)) * 1000
               + longint'(vel_hist[0]) + longint'(vel_hist[1])) / 3;
        vel_hist[1] = vel_hist[0];
        vel_hist[0] = VEL_W'(vel);
        last_angle = measured;
        cand = longint'(integ_acc) + ((err + longint'(last_error)) * 65536) / 2000;
        if (cand > INTEG_MAX)
            cand = INTEG_MAX;
        if (cand < INTEG_MIN)
            cand = INTEG_MIN;
        mag = (err < 0) ? -err : err;
        in_band = mag < longint'(err_thresh);
        if (in_band)
        begin
            // integral product split into whole and fractional halves
            ih = cand >>> FRAC_W;
            il = cand - (ih <<< FRAC_W);
            t = longint'(kp_small) * err - longint'(kd_small) * vel
                + longint'(ki_gain) * ih + ((longint'(ki_gain) * il) >>> FRAC_W);
            band_count++;
        end
        else
        begin
            t = longint'(kp_large) * err - longint'(kd_large) * vel;
            integ_acc = '0;
            cand = 0;
        end
        lim = longint'(torque_lim) <<< FRAC_W;
        if (t > lim || t < -lim)
        begin
            // saturated: integral holds its old value
            t = (t > lim) ? lim : -lim;
            cand = longint'(integ_acc);
            clamp_count++;
        end
        last_error = ERR_W'(err);
        integ_acc = INTEG_W'(cand);
        return TORQUE_W'(t >>> FRAC_W);
    endfunction

    function automatic logic signed [ANGLE_W-1:0] to_angle(input int v);
        if (v > ANGLE_MAX)
            return ANGLE_W'(ANGLE_MAX);
        if (v < ANGLE_MIN)
            return ANGLE_W'(ANGLE_MIN);
        return ANGLE_W'(v);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_extreme();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    task automatic flag_error(input string what, input longint want, input longint got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at cycle %0d: %s expected %0d got %0d",
                     cycle_count, what, want, got);
    endtask

    task automatic push_sample(
        input logic signed [ANGLE_W-1:0] desired,
        input logic signed [ANGLE_W-1:0] measured
    );
        sample_queue.push_back('{desired: desired, measured: measured});
        samples_unsent++;
    endtask

    task automatic wait_idle();
        while (samples_unsent != 0 || torque_expected.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_PROP_LARGE:   kp_large = value;
            REG_DERIV_LARGE:  kd_large = value;
            REG_PROP_SMALL:   kp_small = value;
            REG_DERIV_SMALL:  kd_small = value;
            REG_INTEGRAL:     ki_gain = value;
            REG_THRESHOLD:    err_thresh = value[THRESH_W-1:0];
            REG_TORQUE_LIMIT: torque_lim = value[LIMIT_W-1:0];
            default:          ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_config(input bit extreme);
        if (extreme)
        begin
            write_reg(REG_PROP_LARGE, pick_extreme());
            write_reg(REG_DERIV_LARGE, pick_extreme());
            write_reg(REG_PROP_SMALL, pick_extreme());
            write_reg(REG_DERIV_SMALL, pick_extreme());
            write_reg(REG_INTEGRAL, pick_extreme());
            write_reg(REG_THRESHOLD, pick_extreme());
            write_reg(REG_TORQUE_LIMIT, pick_extreme());
            write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        end
        else
        begin
            write_reg(REG_PROP_LARGE, CFG_DATA_W'($urandom_range(2 * RST_PROP_LARGE)));
            write_reg(REG_DERIV_LARGE, CFG_DATA_W'($urandom_range(2 * RST_DERIV_LARGE)));
            write_reg(REG_PROP_SMALL, CFG_DATA_W'($urandom_range(2 * RST_PROP_SMALL)));
            write_reg(REG_DERIV_SMALL, CFG_DATA_W'($urandom_range(2 * RST_DERIV_SMALL)));
            write_reg(REG_INTEGRAL, CFG_DATA_W'($urandom_range(2 * RST_INTEGRAL)));
            write_reg(REG_THRESHOLD, CFG_DATA_W'($urandom_range(300, 20000)));
            write_reg(REG_TORQUE_LIMIT, CFG_DATA_W'($urandom_range(32768, LIMIT_MAX)));
        end
        settings_used++;
    endtask

    // slow trajectories tracked with small errors, mixed with raw noise
    task automatic queue_tracking(input int count);
        int pos;
        int err;
        int thr;
        int span;
        int pick;
        pos = int'($urandom_range(ANGLE_MAX)) - ANGLE_MAX / 2;
        thr = int'(err_thresh);
        span = 4 * thr + 1000;
        repeat (count)
        begin
            if ($urandom_range(99) < 12)
                push_sample(ANGLE_W'($urandom), ANGLE_W'($urandom));
            else
            begin
                if ($urandom_range(99) < 5)
                    pos = int'($urandom_range(2 * ANGLE_MAX)) - ANGLE_MAX;
                else
                    pos = int'(to_angle(pos + int'($urandom_range(600)) - 300));
                pick = $urandom_range(99);
                if (pick < 65)
                    err = (thr > 1) ? int'($urandom_range(2 * (thr - 1))) - (thr - 1) : 0;
                else if (pick < 75)
                    err = $urandom_range(1) ? thr : -thr;
                else
                    err = int'($urandom_range(2 * span)) - span;
                push_sample(to_angle(pos), to_angle(pos - err));
            end
        end
    endtask

    // sample driver
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            in_taken = 1'b0;
            if (sample_queue.size() != 0 && !(throttle && $urandom_range(99) < 25))
            begin
                next_sample = sample_queue.pop_front();
                in_valid <= 1'b1;
                desired_angle <= next_sample.desired;
                measured_angle <= next_sample.measured;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // torque receiver
    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= !(throttle && $urandom_range(99) < 25);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (torque_expected.size() == 0)
                    flag_error("torque with no sample pending", 0, torque);
                else
                begin
                    torque_want = torque_expected.pop_front();
                    if (torque !== torque_want)
                        flag_error("torque", torque_want, torque);
                end
            end
            if (in_valid && in_ready)
            begin
                torque_expected.push_back(predict_torque(desired_angle, measured_angle));
                samples_unsent--;
                samples_taken++;
                in_taken = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset gains: threshold edges, full-scale angles, a settling track
        push_sample(0, 0);
        push_sample(1311, 0);
        push_sample(1310, 0);
        push_sample(-1311, 0);
        push_sample(-1310, 0);
        push_sample(ANGLE_W'(ANGLE_MAX), ANGLE_W'(ANGLE_MIN));
        push_sample(ANGLE_W'(ANGLE_MIN), ANGLE_W'(ANGLE_MAX));
        push_sample(ANGLE_W'(ANGLE_MAX), ANGLE_W'(ANGLE_MAX));
        push_sample(ANGLE_W'(ANGLE_MIN), ANGLE_W'(ANGLE_MIN));
        push_sample(100, 40);
        push_sample(150, 100);
        push_sample(200, 170);
        push_sample(220, 215);
        push_sample(230, 231);
        wait_idle();

        // every register at full scale, plus a write to an unmapped index
        write_reg(REG_PROP_LARGE, '1);
        write_reg(REG_DERIV_LARGE, '1);
        write_reg(REG_PROP_SMALL, '1);
        write_reg(REG_DERIV_SMALL, '1);
        write_reg(REG_INTEGRAL, '1);
        write_reg(REG_THRESHOLD, '1);
        write_reg(REG_TORQUE_LIMIT, '1);
        write_reg(REG_UNUSED, '1);
        settings_used++;
        push_sample(ANGLE_W'(ANGLE_MAX), ANGLE_W'(ANGLE_MIN));
        push_sample(0, ANGLE_W'(ANGLE_MIN));
        push_sample(0, -1048575);
        push_sample(0, -1048574);
        push_sample(ANGLE_W'(ANGLE_MIN), ANGLE_W'(ANGLE_MAX));
        wait_idle();

        // zero torque limit, threshold back to its reset value
        write_reg(REG_TORQUE_LIMIT, '0);
        write_reg(REG_THRESHOLD, RST_THRESHOLD);
        settings_used++;
        push_sample(500, 0);
        push_sample(-500, 0);
        push_sample(0, 0);
        push_sample(ANGLE_W'(ANGLE_MAX), 0);
        wait_idle();

        for (int phase = 0; phase < 8; phase++)
        begin
            load_config(phase % 2 == 1);
            throttle = (phase != 0);
            queue_tracking(PHASE_ITEMS);
            if (phase == 3)
                hold_request = HOLD_CYCLES;
            wait_idle();
        end

        repeat (60) @(posedge clk);
        if (torque_expected.size() != 0)
            flag_error("torque items never delivered", 0, torque_expected.size());
        $display("%0d samples over %0d register settings: %0d in integral mode, %0d clamped",
                 samples_taken, settings_used, band_count, clamp_count);
        $display("%0d mismatches in %0d cycles", mismatch_count, cycle_count);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* filelist.f */
rtl/gsp_pkg.sv
rtl/gsp_cdiv.sv
rtl/gsp_dp.sv
rtl/gsp_ctrl.sv
rtl/gain_switched_pid_antiwindup.sv
rtl/gsp_chk.sv
bench/gain_switched_pid_antiwindup_test.sv
